>>> hdl/psp_pkg.sv
// Shared types, codes and lookup functions for the plotter stepper pen mechanism.
// No dependencies; used by psp_phase_dec and plotter_stepper_pen_mechanism_core.
package psp_pkg;

   localparam logic [1:0] OP_BUS   = 2'd0;
   localparam logic [1:0] OP_PORT1 = 2'd1;

   localparam logic [1:0] REG_PEN_CHANGE_ZONE = 2'd0;
   localparam logic [1:0] REG_COLOUR_COUNT    = 2'd1;
   localparam logic [1:0] REG_X_REVERSE       = 2'd2;
   localparam logic [1:0] REG_Y_REVERSE       = 2'd3;

   localparam logic [3:0] PHASE_A = 4'hA;
   localparam logic [3:0] PHASE_B = 4'h6;
   localparam logic [3:0] PHASE_C = 4'h5;
   localparam logic [3:0] PHASE_D = 4'h9;

   localparam logic [1:0] PEN_LOWER = 2'b01;
   localparam logic [1:0] PEN_RAISE = 2'b10;

   localparam int         BUSY_BIT     = 4;
   localparam int         CSR_WIDTH    = 10;
   localparam int         ZONE_WIDTH   = 10;
   localparam int         REQ_WIDTH    = 8;
   localparam int         RSP_WIDTH    = 72;
   localparam int         OUT_POS_BITS = 16;

   localparam logic [9:0] ZONE_RESET       = 10'd16;
   localparam logic [2:0] COLOUR_CNT_RESET = 3'd4;

   typedef struct packed {
      logic       valid;
      logic [1:0] slot;
   } phase_slot_type;

   typedef struct packed {
      logic [3:0] last;
      logic       known;
      logic       fwd;
      logic       back;
   } phase_dec_type;

   function automatic phase_slot_type phase_slot(input logic [3:0] ph);
      phase_slot_type s;
      s = '{valid: 1'b1, slot: 2'd0};
      unique case (ph)
         PHASE_A: s.slot = 2'd0;
         PHASE_B: s.slot = 2'd1;
         PHASE_C: s.slot = 2'd2;
         PHASE_D: s.slot = 2'd3;
         default: s.valid = 1'b0;
      endcase
      return s;
   endfunction

   // advance the drum one pen, wrapping at the effective drum size
   function automatic logic [1:0] next_colour(input logic [1:0] c, input logic [2:0] count);
      logic [2:0] v;
      logic [1:0] r;
      v = {1'b0, c} + 3'd1;
      unique case (count)
         3'd0, 3'd1: r = 2'd0;
         3'd2:       r = {1'b0, v[0]};
         3'd3:       r = (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
         default:    r = v[1:0];
      endcase
      return r;
   endfunction

endpackage

>>> hdl/psp_phase_dec.sv
// Four-phase stepper nibble decoder for one axis: tracks the last phase and
// reports a forward or backward step. Depends on psp_pkg.
module psp_phase_dec (
   input  logic                    en,
   input  logic [3:0]              nibble,
   input  logic [3:0]              last_ff,
   input  logic                    known_ff,
   output psp_pkg::phase_dec_type  dec
);
   import psp_pkg::*;

   phase_slot_type sa;
   phase_slot_type sb;
   logic [1:0]     d;

   assign sa = phase_slot(last_ff);
   assign sb = phase_slot(nibble);
   assign d  = sb.slot - sa.slot;

   always_comb begin
      dec = '{last: last_ff, known: known_ff, fwd: 1'b0, back: 1'b0};
      if (en && nibble != 4'd0) begin
         if (!known_ff) begin
            dec.last  = nibble;
            dec.known = 1'b1;
         end else if (nibble != last_ff) begin
            dec.last = nibble;
            if (sa.valid && sb.valid) begin
               dec.fwd  = (d == 2'd1);
               dec.back = (d == 2'd3);
            end
         end
      end
   end

endmodule

>>> hdl/plotter_stepper_pen_mechanism_core.sv
// Plotter stepper and pen mechanism: decodes port writes into carriage/paper
// positions, pen state and stroke records.
// Depends on psp_pkg and psp_phase_dec.
//
// Usage:
//   req_*  : one port write per request. req_tuser = operation (0 bus steppers,
//            1 port one pen/busy, others ignored), req_tdata = port byte.
//   rsp_*  : one result per request: stroke flag, start/end position, pen colour,
//            pen latch and busy flag.
//   csr_*  : register write port, taken on any clock with csr_we high; write
//            only while no request is in flight.
// Result: registered; rsp_tvalid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while results are taken; the state update and
//   the result register are a single pass of shallow logic.
// Stall: the result register holds while rsp_tready is low; req_tready drops
//   only when a result is held and not being taken.
// Reset: positions, phases, pen, colour and busy clear; registers return to
//   zone 16, four pens, X reversed, Y forward; no result is pending.
module plotter_stepper_pen_mechanism_core #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [psp_pkg::REQ_WIDTH-1:0]    req_tdata,  // [7:0] port_value
   input  logic [1:0]                       req_tuser,  // [1:0] operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] stroke_valid, [16:1] start_x, [32:17] start_y, [48:33] end_x,
   // [64:49] end_y, [66:65] pen_colour, [67] pen_is_down, [68] busy_flag, zero above
   output logic [psp_pkg::RSP_WIDTH-1:0]    rsp_tdata,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_addr,
   input  logic [psp_pkg::CSR_WIDTH-1:0]    csr_wdata
);
   import psp_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int CW = (PW > ZONE_WIDTH) ? PW : ZONE_WIDTH;
   localparam logic [PW-1:0] X_MAX = {PW{1'b1}};
   localparam logic [PW-1:0] Y_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0] Y_MIN = {1'b1, {(PW-1){1'b0}}};

   logic [ZONE_WIDTH-1:0] zone_ff;
   logic [2:0]            colour_cnt_ff;
   logic                  x_rev_ff;
   logic                  y_rev_ff;

   logic [3:0]    x_last_ff, y_last_ff;
   logic          x_known_ff, y_known_ff;
   logic [PW-1:0] carriage_ff, carriage_in;
   logic [PW-1:0] paper_ff, paper_in;
   logic          pen_ff, pen_in;
   logic [1:0]    colour_ff, colour_in;
   logic          inside_ff, inside_in;
   logic          busy_ff, busy_in;

   logic                 rsp_valid_ff;
   logic [RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   phase_dec_type xdec, ydec;
   logic          is_bus, is_port1, accept;
   logic          x_up, x_down, y_up, y_down, x_step, in_zone, stroke;
   logic [OUT_POS_BITS-1:0] sx16, sy16, ex16, ey16;

   assign is_bus   = (req_tuser == OP_BUS);
   assign is_port1 = (req_tuser == OP_PORT1);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   psp_phase_dec u_x_dec (
      .en       (is_bus),
      .nibble   (req_tdata[3:0]),
      .last_ff  (x_last_ff),
      .known_ff (x_known_ff),
      .dec      (xdec)
   );

   psp_phase_dec u_y_dec (
      .en       (is_bus),
      .nibble   (req_tdata[7:4]),
      .last_ff  (y_last_ff),
      .known_ff (y_known_ff),
      .dec      (ydec)
   );

   assign x_up   = x_rev_ff ? xdec.back : xdec.fwd;
   assign x_down = x_rev_ff ? xdec.fwd  : xdec.back;
   assign y_up   = y_rev_ff ? ydec.back : ydec.fwd;
   assign y_down = y_rev_ff ? ydec.fwd  : ydec.back;
   assign x_step = xdec.fwd || xdec.back;

   always_comb begin
      carriage_in = carriage_ff;
      if (x_up && carriage_ff != X_MAX) begin
         carriage_in = carriage_ff + PW'(1);
      end else if (x_down && carriage_ff != '0) begin
         carriage_in = carriage_ff - PW'(1);
      end
   end

   always_comb begin
      paper_in = paper_ff;
      if (y_up && paper_ff != Y_MAX) begin
         paper_in = paper_ff + PW'(1);
      end else if (y_down && paper_ff != Y_MIN) begin
         paper_in = paper_ff - PW'(1);
      end
   end

   assign in_zone = CW'(carriage_in) < CW'(zone_ff);

   always_comb begin
      colour_in = colour_ff;
      inside_in = inside_ff;
      if (x_step) begin
         inside_in = in_zone;
         if (in_zone && !inside_ff) begin
            colour_in = next_colour(colour_ff, colour_cnt_ff);
         end
      end
   end

   always_comb begin
      pen_in  = pen_ff;
      busy_in = busy_ff;
      if (is_port1) begin
         busy_in = req_tdata[BUSY_BIT];
         unique case (req_tdata[1:0])
            PEN_LOWER: pen_in = 1'b1;
            PEN_RAISE: pen_in = 1'b0;
            default:   pen_in = pen_ff;
         endcase
      end
   end

   assign stroke = pen_ff && (carriage_in != carriage_ff || paper_in != paper_ff);

   generate
      if (PW >= OUT_POS_BITS) begin : g_trunc
         assign sx16 = carriage_ff[OUT_POS_BITS-1:0];
         assign ex16 = carriage_in[OUT_POS_BITS-1:0];
         assign sy16 = paper_ff[OUT_POS_BITS-1:0];
         assign ey16 = paper_in[OUT_POS_BITS-1:0];
      end else begin : g_extend
         assign sx16 = {{(OUT_POS_BITS-PW){1'b0}}, carriage_ff};
         assign ex16 = {{(OUT_POS_BITS-PW){1'b0}}, carriage_in};
         assign sy16 = {{(OUT_POS_BITS-PW){paper_ff[PW-1]}}, paper_ff};
         assign ey16 = {{(OUT_POS_BITS-PW){paper_in[PW-1]}}, paper_in};
      end
   endgenerate

   assign rsp_data_in = {3'b000, busy_in, pen_in, colour_in, ey16, ex16, sy16, sx16, stroke};

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff       <= ZONE_RESET;
         colour_cnt_ff <= COLOUR_CNT_RESET;
         x_rev_ff      <= 1'b1;
         y_rev_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PEN_CHANGE_ZONE: zone_ff       <= csr_wdata[ZONE_WIDTH-1:0];
            REG_COLOUR_COUNT:    colour_cnt_ff <= csr_wdata[2:0];
            REG_X_REVERSE:       x_rev_ff      <= csr_wdata[0];
            REG_Y_REVERSE:       y_rev_ff      <= csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_last_ff   <= '0;
         x_known_ff  <= 1'b0;
         y_last_ff   <= '0;
         y_known_ff  <= 1'b0;
         carriage_ff <= '0;
         paper_ff    <= '0;
         pen_ff      <= 1'b0;
         colour_ff   <= '0;
         inside_ff   <= 1'b0;
         busy_ff     <= 1'b0;
      end else if (accept) begin
         x_last_ff   <= xdec.last;
         x_known_ff  <= xdec.known;
         y_last_ff   <= ydec.last;
         y_known_ff  <= ydec.known;
         carriage_ff <= carriage_in;
         paper_ff    <= paper_in;
         pen_ff      <= pen_in;
         colour_ff   <= colour_in;
         inside_ff   <= inside_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no result");

   a_stroke_pen_down : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[67])
      else $error("stroke reported with pen up");

   a_stroke_moved : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[32:1] != rsp_tdata[64:33]))
      else $error("stroke reported without movement");

   a_port1_no_move : assert property (@(posedge clock) disable iff (reset)
      (accept && !is_bus) |=> (rsp_tdata[32:1] == rsp_tdata[64:33] && !rsp_tdata[0]))
      else $error("non-bus write moved the mechanism");

endmodule

>>> test/plotter_stepper_pen_mechanism_core_tb.sv
// Self-checking testbench for plotter_stepper_pen_mechanism_core: directed table, random
// phase walks under several register settings, then steady carriage/paper sweeps.
// Depends on psp_pkg and the core RTL only.
`timescale 1ns / 1ps

module plotter_stepper_pen_mechanism_core_tb;
   import psp_pkg::*;

   localparam logic [1:0] OP_SPARE2 = 2'd2;
   localparam logic [1:0] OP_SPARE3 = 2'd3;
   localparam logic [15:0] CARRIAGE_MAX = 16'hFFFF;
   localparam logic signed [15:0] PAPER_MAX = 16'sh7FFF;
   localparam logic signed [15:0] PAPER_MIN = 16'sh8000;
   localparam int RANDOM_PER_PHASE = 55;
   localparam int SWEEP_LEN = 40;
   localparam int PLAN_LEN = 22;

   typedef struct packed {
      logic        busy;
      logic        pen;
      logic [1:0]  colour;
      logic [15:0] end_y;
      logic [15:0] end_x;
      logic [15:0] start_y;
      logic [15:0] start_x;
      logic        stroke;
   } pen_report_type;

   typedef struct packed {
      logic [1:0]     op;
      logic [7:0]     val;
      logic           typed;
      pen_report_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;   // [7:0] port_value
   logic [1:0] req_tuser = '0;             // [1:0] operation
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] stroke_valid, [16:1] start_x, [32:17] start_y, [48:33] end_x,
   // [64:49] end_y, [66:65] pen_colour, [67] pen_is_down, [68] busy_flag
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_addr = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   plotter_stepper_pen_mechanism_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // mechanism state mirror
   logic [9:0]         zone_cfg;
   logic [2:0]         pens_cfg;
   logic               x_rev_cfg, y_rev_cfg;
   logic [3:0]         x_ph, y_ph;
   logic               x_seen, y_seen;
   logic [15:0]        carriage;
   logic signed [15:0] paper;
   logic               pen_lowered, busy, in_zone_q;
   logic [1:0]         colour;

   pen_report_type awaited[$];
   int  mismatch_count = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;
   plan_row_type plan [PLAN_LEN];

   function automatic int slot_of(logic [3:0] ph);
      case (ph)
         PHASE_A: return 0;
         PHASE_B: return 1;
         PHASE_C: return 2;
         PHASE_D: return 3;
         default: return -1;
      endcase
   endfunction

   function automatic logic [3:0] phase_at(int s);
      case (s & 3)
         0: return PHASE_A;
         1: return PHASE_B;
         2: return PHASE_C;
         default: return PHASE_D;
      endcase
   endfunction

   function automatic int phase_move(logic [3:0] last, logic seen, logic [3:0] ph);
      int a, b, d;
      if (!seen || ph == last) return 0;
      a = slot_of(last);
      b = slot_of(ph);
      if (a < 0 || b < 0) return 0;
      d = (b - a) & 3;
      if (d == 1) return 1;
      if (d == 3) return -1;
      return 0;
   endfunction

   function automatic plan_row_type row(logic [1:0] op, logic [7:0] val, logic typed,
                                        pen_report_type want);
      return {op, val, typed, want};
   endfunction

   task automatic predict_write(input logic [1:0] op, input logic [7:0] val,
                                output pen_report_type r);
      logic [15:0]        sx;
      logic signed [15:0] sy;
      int                 dx, dy, drum;
      logic               now_in;
      sx = carriage;
      sy = paper;
      r = '0;
      if (op == OP_BUS) begin
         dx = 0;
         dy = 0;
         if (val[3:0] != 4'd0) begin
            dx = phase_move(x_ph, x_seen, val[3:0]);
            x_ph = val[3:0];
            x_seen = 1'b1;
         end
         if (val[7:4] != 4'd0) begin
            dy = phase_move(y_ph, y_seen, val[7:4]);
            y_ph = val[7:4];
            y_seen = 1'b1;
         end
         if (x_rev_cfg) dx = -dx;
         if (y_rev_cfg) dy = -dy;
         if (dx != 0) begin
            if (dx > 0) begin
               if (carriage != CARRIAGE_MAX) carriage = carriage + 16'd1;
            end else if (carriage != 16'd0) begin
               carriage = carriage - 16'd1;
            end
            now_in = carriage < {6'd0, zone_cfg};
            drum = (pens_cfg == 3'd0) ? 1 : (pens_cfg > 3'd4) ? 4 : int'(pens_cfg);
            if (now_in && !in_zone_q) colour = 2'((int'(colour) + 1) % drum);
            in_zone_q = now_in;
         end
         if (dy > 0 && paper != PAPER_MAX) paper = paper + 16'sd1;
         else if (dy < 0 && paper != PAPER_MIN) paper = paper - 16'sd1;
         r.stroke = (dx != 0 || dy != 0) && pen_lowered && (sx != carriage || sy != paper);
      end else if (op == OP_PORT1) begin
         if (val[1:0] == PEN_LOWER) pen_lowered = 1'b1;
         else if (val[1:0] == PEN_RAISE) pen_lowered = 1'b0;
         busy = val[BUSY_BIT];
      end
      r.start_x = sx;
      r.start_y = sy;
      r.end_x = carriage;
      r.end_y = paper;
      r.colour = colour;
      r.pen = pen_lowered;
      r.busy = busy;
   endtask

   task automatic push_request(input logic [1:0] op, input logic [7:0] val,
                               input logic typed, input pen_report_type want);
      pen_report_type r;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= val;
      do @(posedge clock); while (!req_tready);
      predict_write(op, val, r);
      awaited.push_back(typed ? want : r);
   endtask

   // drop valid and hold until every result is back
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_WIDTH-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PEN_CHANGE_ZONE: zone_cfg = value[ZONE_WIDTH-1:0];
         REG_COLOUR_COUNT:    pens_cfg = value[2:0];
         REG_X_REVERSE:       x_rev_cfg = value[0];
         default:             y_rev_cfg = value[0];
      endcase
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic apply_setting(input int zone, input int pens, input int xr, input int yr);
      write_reg(REG_PEN_CHANGE_ZONE, 10'(zone));
      write_reg(REG_COLOUR_COUNT, {7'($urandom_range(0, 127)), 3'(pens)});
      write_reg(REG_X_REVERSE, {9'($urandom_range(0, 511)), 1'(xr)});
      write_reg(REG_Y_REVERSE, {9'($urandom_range(0, 511)), 1'(yr)});
   endtask

   // mostly single steps along a persistent direction, some zero, same, jump and bad nibbles
   task automatic pick_phase(inout int slot, inout int dir, output logic [3:0] ph);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         if ($urandom_range(0, 3) == 0) dir = -dir;
         slot = (slot + dir) & 3;
         ph = phase_at(slot);
      end else if (r < 70) begin
         ph = 4'd0;
      end else if (r < 78) begin
         ph = phase_at(slot);
      end else if (r < 88) begin
         slot = (slot + 2) & 3;
         ph = phase_at(slot);
      end else begin
         ph = 4'($urandom_range(1, 15));
         if (slot_of(ph) >= 0) slot = slot_of(ph);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch
      pen_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[68:0];
         if (awaited.size() == 0) begin
            $display("%0t ns: result expected none, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited.pop_front();
            check_field("stroke_valid", 16'(want.stroke), 16'(got.stroke));
            check_field("start_x", want.start_x, got.start_x);
            check_field("start_y", want.start_y, got.start_y);
            check_field("end_x", want.end_x, got.end_x);
            check_field("end_y", want.end_y, got.end_y);
            check_field("pen_colour", 16'(want.colour), 16'(got.colour));
            check_field("pen_is_down", 16'(want.pen), 16'(got.pen));
            check_field("busy_flag", 16'(want.busy), 16'(got.busy));
            check_field("padding", 16'd0, 16'(rsp_tdata[RSP_WIDTH-1:69]));
         end
      end
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int          i, k, n, r, xs, ys, xd, yd;
      logic [3:0]  xn, yn;
      zone_cfg = ZONE_RESET;
      pens_cfg = COLOUR_CNT_RESET;
      x_rev_cfg = 1'b1;
      y_rev_cfg = 1'b0;
      x_ph = '0;
      y_ph = '0;
      x_seen = 1'b0;
      y_seen = 1'b0;
      carriage = '0;
      paper = '0;
      pen_lowered = 1'b0;
      busy = 1'b0;
      in_zone_q = 1'b0;
      colour = '0;

      plan[0]  = row(OP_BUS,    8'h00, 1'b1, '0);
      plan[1]  = row(OP_PORT1,  8'h11, 1'b1, '{1'b1, 1'b1, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
      plan[2]  = row(OP_BUS,    8'hAA, 1'b1, '{1'b1, 1'b1, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
      plan[3]  = row(OP_BUS,    8'h66, 1'b0, '0);
      plan[4]  = row(OP_BUS,    8'h55, 1'b0, '0);
      plan[5]  = row(OP_BUS,    8'h99, 1'b0, '0);
      plan[6]  = row(OP_BUS,    8'h5A, 1'b0, '0);
      plan[7]  = row(OP_BUS,    8'h03, 1'b0, '0);
      plan[8]  = row(OP_BUS,    8'h0A, 1'b0, '0);
      plan[9]  = row(OP_BUS,    8'h09, 1'b0, '0);
      plan[10] = row(OP_BUS,    8'h05, 1'b0, '0);
      plan[11] = row(OP_BUS,    8'h06, 1'b0, '0);
      plan[12] = row(OP_BUS,    8'h6A, 1'b0, '0);
      plan[13] = row(OP_PORT1,  8'h02, 1'b0, '0);
      plan[14] = row(OP_BUS,    8'h0A, 1'b0, '0);
      plan[15] = row(OP_PORT1,  8'hFD, 1'b0, '0);
      plan[16] = row(OP_PORT1,  8'h03, 1'b0, '0);
      plan[17] = row(OP_PORT1,  8'hEC, 1'b0, '0);
      plan[18] = row(OP_SPARE2, 8'hFF, 1'b0, '0);
      plan[19] = row(OP_SPARE3, 8'h55, 1'b0, '0);
      plan[20] = row(OP_BUS,    8'hFF, 1'b0, '0);
      plan[21] = row(OP_BUS,    8'h69, 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (i = 0; i < PLAN_LEN; i++)
         push_request(plan[i].op, plan[i].val, plan[i].typed, plan[i].want);
      settle();

      xs = 0;
      ys = 0;
      xd = 1;
      yd = -1;
      for (k = 0; k < 6; k++) begin
         case (k)
            0: apply_setting(2, 0, 0, 1);
            1: apply_setting(0, 7, 1, 0);
            2: apply_setting(1023, 1, 0, 0);
            3: apply_setting(5, 3, 1, 1);
            4: apply_setting(3, 2, 0, 1);
            default: apply_setting($urandom_range(0, 24), $urandom_range(0, 7),
                                   $urandom_range(0, 1), $urandom_range(0, 1));
         endcase
         quiet = (k == 3);
         n = 0;
         while (n < RANDOM_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               pick_phase(xs, xd, xn);
               pick_phase(ys, yd, yn);
               push_request(OP_BUS, {yn, xn}, 1'b0, '0);
               n++;
            end else if (r < 85) begin
               push_request(OP_PORT1, 8'($urandom_range(0, 255)), 1'b0, '0);
               n++;
            end else if (r < 90) begin
               push_request(2'($urandom_range(2, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
               push_request(OP_BUS, 8'($urandom_range(0, 255)), 1'b0, '0);
               n++;
            end
         end
         settle();
      end

      // march both axes one way with the pen down, then reverse both and march back
      quiet = 1'b1;
      apply_setting(600, 5, 0, 0);
      push_request(OP_PORT1, {3'd0, 1'b1, 2'd0, PEN_LOWER}, 1'b0, '0);
      for (k = 0; k < SWEEP_LEN; k++)
         push_request(OP_BUS, {phase_at(k), phase_at(k)}, 1'b0, '0);
      settle();
      apply_setting(600, 4, 1, 1);
      for (k = 0; k < SWEEP_LEN; k++)
         push_request(OP_BUS, {phase_at(k), phase_at(k)}, 1'b0, '0);
      settle();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> plotter_stepper_pen_mechanism_core.f
hdl/psp_pkg.sv
hdl/psp_phase_dec.sv
hdl/plotter_stepper_pen_mechanism_core.sv
test/plotter_stepper_pen_mechanism_core_tb.sv
